/* src/ibcs_pkg.sv */
// Shared types and constants for the IMU bias calibrate-and-scale block.
// Used by the serial divider lanes and by the top level; no dependencies.
`timescale 1ns / 1ps

package ibcs_pkg;

    // Geometry of one sample
    localparam int N_AXES  = 6;   // accel x, y, z, gyro x, y, z
    localparam int N_LANES = 4;   // serial divider lanes
    localparam int LANE_TEMP = 3; // lane that handles temperature
    localparam int RAW_W   = 16;
    localparam int SUM_W   = 33;
    localparam int BIAS_W  = 25;
    localparam int ACC_W   = 25;
    localparam int GYRO_W  = 21;
    localparam int TEMP_W  = 16;
    localparam int DIFF_W  = 26;  // raw*256 - bias, before saturation
    localparam int CNT_W   = 16;

    // Divider lane sizes
    localparam int REM_W   = 17;
    localparam int QUO_W   = 24;
    localparam int STEP_W  = 5;
    localparam int CONV_STEPS = 21; // quotient bits for gyro and temperature
    localparam int CAL_STEPS  = 24; // quotient bits for a bias average

    // Operation codes carried in tuser
    localparam logic OP_CONVERT   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    // Arithmetic constants
    localparam logic signed [SUM_W-1:0]  ONE_G       = 33'sd4096;
    localparam logic [REM_W-1:0]         GYRO_DEN    = 17'd164;    // 2 * 82
    localparam logic [REM_W-1:0]         TEMP_DEN    = 17'd66774;  // 2 * 33387
    localparam logic [28:0]              GYRO_RND    = 29'd82;
    localparam logic [31:0]              TEMP_MUL    = 32'd51200;  // 2 * 25600
    localparam logic [31:0]              TEMP_RND    = 32'd33387;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 16'sd5376;  // 21.0 C in Q8.8
    localparam logic signed [DIFF_W-1:0] ACC_MAX     = 26'sd16777215;
    localparam logic signed [DIFF_W-1:0] ACC_MIN     = -26'sd16777216;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CONV,
        ST_OUT,
        ST_CAL_LOAD,
        ST_CAL_RUN,
        ST_CAL_STORE
    } state_t;

    // Control of one divider lane
    typedef struct packed {
        logic load;
        logic step;
    } sdiv_ctl_t;

endpackage

/* src/ibcs_sdiv.sv */
// Bit-serial restoring divider lane: one quotient bit per cycle while ctl.step is high.
// Depends on ibcs_pkg for widths and the lane control struct.
`timescale 1ns / 1ps

module ibcs_sdiv (
    input  logic                          aclk,
    input  ibcs_pkg::sdiv_ctl_t           ctl,
    input  logic [ibcs_pkg::REM_W-1:0]    load_rem,  // dividend bits above the quotient
    input  logic [ibcs_pkg::QUO_W-1:0]    load_quo,  // remaining dividend bits, MSB first
    input  logic [ibcs_pkg::REM_W-1:0]    divisor,
    output logic [ibcs_pkg::QUO_W-1:0]    quotient
);
    import ibcs_pkg::*;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] den_reg, den_next;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        diff     = trial - {1'b0, den_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (ctl.load) begin
            rem_next = load_rem;
            quo_next = load_quo;
            den_next = divisor;
        end else if (ctl.step) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[REM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[REM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;

endmodule

/* src/imu_bias_calibrate_and_scale.sv */
// IMU sample conversion with bias removal and on-line bias calibration.
// Each sample passes ST_LOAD, ST_CONV and ST_OUT; the input opens again once the result enters the
// output register, so one sample is in flight at a time. A sample that completes calibration holds
// the input for two further passes of divisions by the sample count.
// Rate is set by the four bit-serial divider lanes (21 quotient bits per sample).
// Reset (aresetn low, synchronous): biases, sums and count cleared, calib_samples = 1.
`timescale 1ns / 1ps

module imu_bias_calibrate_and_scale (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration: calib_samples
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    // Input samples
    input  logic          s_tvalid,
    output logic          s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, die_temp_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
    input  logic [111:0]  s_tdata,
    input  logic [0:0]    s_tuser,   // operation
    // Results
    output logic          m_tvalid,
    input  logic          m_tready,
    // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out, gyro_z_out,
    // temperature_out, zero pad
    output logic [159:0]  m_tdata,
    output logic [0:0]    m_tuser    // bias_updated
);
    import ibcs_pkg::*;

    // ------------------------------------------------------------------
    // State
    state_t state_reg, state_next;

    logic [CNT_W-1:0]               samples_reg;
    logic [CNT_W-1:0]               count_reg;
    logic signed [SUM_W-1:0]        sums_reg [N_AXES];
    logic signed [BIAS_W-1:0]       bias_reg [N_AXES];
    logic signed [DIFF_W-1:0]       diff_reg [N_AXES];
    logic signed [RAW_W-1:0]        temp_raw_reg;
    logic                           cal_done_reg;
    logic [STEP_W-1:0]              step_cnt_reg;
    logic                           pass_reg;
    logic                           m_tvalid_reg;
    logic [159:0]                   m_tdata_reg;
    logic [0:0]                     m_tuser_reg;

    // Control decode
    logic      in_acc;
    logic      out_load;
    logic      step_last;
    sdiv_ctl_t lane_ctl;

    // Beat unpacking
    logic signed [RAW_W-1:0] in_raw [N_AXES];
    logic signed [RAW_W-1:0] in_temp;
    logic [CNT_W-1:0]        count_inc;
    logic [CNT_W-1:0]        target;
    logic                    cal_hit;

    // Lane data
    logic [REM_W-1:0] lane_rem [N_LANES];
    logic [QUO_W-1:0] lane_quo [N_LANES];
    logic [REM_W-1:0] lane_den [N_LANES];
    logic [QUO_W-1:0] lane_q   [N_LANES];

    // Result assembly
    logic signed [ACC_W-1:0]  acc_res  [3];
    logic signed [GYRO_W-1:0] gyro_res [3];
    logic signed [TEMP_W-1:0] temp_res;
    logic signed [BIAS_W-1:0] cal_res  [N_LANES];

    assign in_raw[0] = s_tdata[15:0];
    assign in_raw[1] = s_tdata[31:16];
    assign in_raw[2] = s_tdata[47:32];
    assign in_temp   = s_tdata[63:48];
    assign in_raw[3] = s_tdata[79:64];
    assign in_raw[4] = s_tdata[95:80];
    assign in_raw[5] = s_tdata[111:96];

    // Calibration count check (zero sample count acts as one)
    assign count_inc = count_reg + 16'd1;
    assign target    = (samples_reg == '0) ? 16'd1 : samples_reg;
    assign cal_hit   = (count_inc >= target);

    // ------------------------------------------------------------------
    // FSM: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_LOAD;
            ST_LOAD:      state_next = ST_CONV;
            ST_CONV:      if (step_last) state_next = ST_OUT;
            ST_OUT:       if (out_load) state_next = cal_done_reg ? ST_CAL_LOAD : ST_IDLE;
            ST_CAL_LOAD:  state_next = ST_CAL_RUN;
            ST_CAL_RUN:   if (step_last) state_next = ST_CAL_STORE;
            ST_CAL_STORE: state_next = pass_reg ? ST_IDLE : ST_CAL_LOAD;
            default:      state_next = ST_IDLE;
        endcase
    end

    // FSM: decoded controls
    always_comb begin
        s_tready      = 1'b0;
        lane_ctl.load = 1'b0;
        lane_ctl.step = 1'b0;
        step_last     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:      s_tready = 1'b1;
            ST_LOAD:      lane_ctl.load = 1'b1;
            ST_CONV: begin
                lane_ctl.step = 1'b1;
                step_last     = (step_cnt_reg == STEP_W'(CONV_STEPS - 1));
            end
            ST_OUT:       out_load = !m_tvalid_reg || m_tready;
            ST_CAL_LOAD:  lane_ctl.load = 1'b1;
            ST_CAL_RUN: begin
                lane_ctl.step = 1'b1;
                step_last     = (step_cnt_reg == STEP_W'(CAL_STEPS - 1));
            end
            ST_CAL_STORE: ;
            default:      ;
        endcase
    end

    assign in_acc = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Lane operands: rounding numerators for conversion, |sum|*256 for calibration
    always_comb begin
        logic [DIFF_W-1:0] dmag;
        logic [28:0]       gnum;
        logic [RAW_W:0]    tmag;
        logic [31:0]       tnum;
        logic [SUM_W-1:0]  smag;
        logic [2:0]        axis;
        dmag = '0;
        gnum = '0;
        tmag = '0;
        tnum = '0;
        smag = '0;
        axis = '0;
        for (int k = 0; k < N_LANES; k++) begin
            lane_rem[k] = '0;
            lane_quo[k] = '0;
            lane_den[k] = TEMP_DEN;
        end
        if (state_reg == ST_CAL_LOAD) begin
            for (int k = 0; k < N_LANES; k++) begin
                axis        = (pass_reg && k < 2) ? 3'(k + 4) : 3'(k);
                smag        = sums_reg[axis][SUM_W-1] ? SUM_W'(-sums_reg[axis])
                                                      : SUM_W'(sums_reg[axis]);
                lane_rem[k] = smag[SUM_W-1:16];
                lane_quo[k] = {smag[15:0], 8'b0};
                lane_den[k] = {1'b0, count_reg};
            end
        end else begin
            // gyro: round(d*5/82) = floor((10|d| + 82) / 164)
            for (int k = 0; k < 3; k++) begin
                dmag        = diff_reg[k+3][DIFF_W-1] ? DIFF_W'(-diff_reg[k+3])
                                                      : DIFF_W'(diff_reg[k+3]);
                gnum        = ({3'b0, dmag} << 3) + ({3'b0, dmag} << 1) + GYRO_RND;
                lane_rem[k] = {9'b0, gnum[28:21]};
                lane_quo[k] = {gnum[20:0], 3'b0};
                lane_den[k] = GYRO_DEN;
            end
            // temperature: round(t*25600/33387)
            tmag = temp_raw_reg[RAW_W-1] ? (RAW_W+1)'(-{temp_raw_reg[RAW_W-1], temp_raw_reg})
                                         : {1'b0, temp_raw_reg};
            tnum = 32'({15'b0, tmag} * TEMP_MUL) + TEMP_RND;
            lane_rem[LANE_TEMP] = {6'b0, tnum[31:21]};
            lane_quo[LANE_TEMP] = {tnum[20:0], 3'b0};
            lane_den[LANE_TEMP] = TEMP_DEN;
        end
    end

    for (genvar k = 0; k < N_LANES; k++) begin : g_lane
        ibcs_sdiv u_sdiv (
            .aclk     (aclk),
            .ctl      (lane_ctl),
            .load_rem (lane_rem[k]),
            .load_quo (lane_quo[k]),
            .divisor  (lane_den[k]),
            .quotient (lane_q[k])
        );
    end

    // ------------------------------------------------------------------
    // Result values: saturated accel, signed gyro and temperature quotients, signed bias averages
    always_comb begin
        logic signed [GYRO_W-1:0] gq;
        logic signed [TEMP_W-1:0] tq;
        logic signed [BIAS_W-1:0] cq;
        logic [2:0]               axis;
        gq   = '0;
        cq   = '0;
        axis = '0;
        for (int k = 0; k < 3; k++) begin
            if (diff_reg[k] > ACC_MAX)      acc_res[k] = ACC_MAX[ACC_W-1:0];
            else if (diff_reg[k] < ACC_MIN) acc_res[k] = ACC_MIN[ACC_W-1:0];
            else                            acc_res[k] = diff_reg[k][ACC_W-1:0];
            gq          = lane_q[k][GYRO_W-1:0];
            gyro_res[k] = diff_reg[k+3][DIFF_W-1] ? -gq : gq;
        end
        tq       = lane_q[LANE_TEMP][TEMP_W-1:0];
        temp_res = (temp_raw_reg[RAW_W-1] ? -tq : tq) + TEMP_OFFSET;
        for (int k = 0; k < N_LANES; k++) begin
            axis       = (pass_reg && k < 2) ? 3'(k + 4) : 3'(k);
            cq         = {1'b0, lane_q[k]};
            cal_res[k] = sums_reg[axis][SUM_W-1] ? -cq : cq;
        end
    end

    // ------------------------------------------------------------------
    // Control and calibration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            samples_reg  <= 16'd1;
            count_reg    <= '0;
            cal_done_reg <= 1'b0;
            step_cnt_reg <= '0;
            pass_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < N_AXES; i++) begin
                sums_reg[i] <= '0;
                bias_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) samples_reg <= cfg_wr_data;

            // accumulate a calibration beat
            if (in_acc) begin
                cal_done_reg <= (s_tuser[0] == OP_CALIBRATE) && cal_hit;
                if (s_tuser[0] == OP_CALIBRATE) begin
                    count_reg <= count_inc;
                    for (int i = 0; i < N_AXES; i++) begin
                        sums_reg[i] <= sums_reg[i] + SUM_W'(in_raw[i])
                                       - ((i == 2) ? ONE_G : '0);
                    end
                end
            end

            // step counter for the divider lanes
            if (lane_ctl.load)      step_cnt_reg <= '0;
            else if (lane_ctl.step) step_cnt_reg <= step_cnt_reg + STEP_W'(1);

            if (state_reg == ST_OUT) pass_reg <= 1'b0;

            // write back the averages, clear the run after the second pass
            if (state_reg == ST_CAL_STORE) begin
                for (int k = 0; k < N_LANES; k++) begin
                    if (!pass_reg)  bias_reg[k]   <= cal_res[k];
                    else if (k < 2) bias_reg[k+4] <= cal_res[k];
                end
                if (pass_reg) begin
                    count_reg    <= '0;
                    cal_done_reg <= 1'b0;
                    for (int i = 0; i < N_AXES; i++) sums_reg[i] <= '0;
                end
                pass_reg <= 1'b1;
            end

            // output register
            if (out_load)               m_tvalid_reg <= 1'b1;
            else if (m_tready)          m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            temp_raw_reg <= in_temp;
            for (int i = 0; i < N_AXES; i++) begin
                diff_reg[i] <= DIFF_W'($signed({in_raw[i], 8'b0})) - DIFF_W'(bias_reg[i]);
            end
        end
        if (out_load) begin
            m_tdata_reg <= {6'b0, temp_res, gyro_res[2], gyro_res[1], gyro_res[0],
                            acc_res[2], acc_res[1], acc_res[0]};
            m_tuser_reg <= cal_done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Checks
    a_accept_starts_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> state_reg == ST_LOAD)
        else $error("accepted beat did not start a conversion");

    a_cal_only_when_due: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CAL_LOAD |-> cal_done_reg)
        else $error("calibration pass without a completed run");

    a_flag_follows_run: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg && (m_tuser_reg[0] == $past(cal_done_reg)))
        else $error("bias_updated does not match the calibration run");

    a_run_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CAL_STORE && pass_reg) |=> count_reg == '0 && state_reg == ST_IDLE)
        else $error("calibration run not cleared after bias update");

endmodule
